// ===== rtl/srdx_pkg.sv =====
package srdx_pkg;

   // Character codes that steer the line parser.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_THREE   = 8'h33;

   // Width of one text character and of one payload byte.
   localparam int CHAR_WIDTH = 8;
   localparam int BYTE_WIDTH = 8;

   // Position of the parser within one text line.
   typedef enum logic [2:0] {
      PH_LINE_START = 3'd0,
      PH_TYPE       = 3'd1,
      PH_COUNT_HI   = 3'd2,
      PH_COUNT_LO   = 3'd3,
      PH_ADDR       = 3'd4,
      PH_DATA_HI    = 3'd5,
      PH_DATA_LO    = 3'd6,
      PH_SKIP       = 3'd7
   } phase_type;

   // Result of decoding one hex character.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   // Decodes 0-9, A-F and a-f; any other character is flagged as not hex.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type result;
      result.valid = 1'b1;
      result.value = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         result.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         result.value = c[3:0] + 4'd9;
      end else begin
         result.valid = 1'b0;
         result.value = 4'd0;
      end
      return result;
   endfunction

endpackage

// ===== rtl/srecord_data_extractor_unit.sv =====
// Extracts the payload bytes of S1, S2 and S3 records from a Motorola
// S-record text stream that arrives one ASCII character per input beat.
// Each output beat carries one data byte, with tlast set on the final byte
// of a record; address, checksum and all other record types are skipped,
// and a newline always returns the parser to the start of a line. One
// character is taken every clock cycle: the parser state is registered on
// each accepted character and each byte lands in an output register, so
// the only thing that holds up the input is a full output register that
// the downstream side is not taking. A result appears in the cycle after
// the second hex digit of its pair is accepted.
module srecord_data_extractor_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srdx_pkg::CHAR_WIDTH-1:0] req_tdata,  // [7:0] text_char
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srdx_pkg::BYTE_WIDTH-1:0] rsp_tdata,  // [7:0] data_byte
   output logic                           rsp_tlast   // record_last
);
   import srdx_pkg::*;

   // Parser state.
   phase_type                phase_ff, phase_in;
   logic [3:0]               addr_left_ff, addr_left_in;
   logic [3:0]               addr_total_ff, addr_total_in;
   logic [7:0]               bytes_left_ff, bytes_left_in;
   logic [3:0]               high_nibble_ff, high_nibble_in;
   logic                     high_valid_ff, high_valid_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     emit;
   logic                     emit_last;
   hex_type                  digit;
   logic [7:0]               pair;
   logic [2:0]               addr_bytes;
   logic [3:0]               addr_left_dec;
   logic [7:0]               bytes_left_dec;

   // A new character is taken whenever the output register is free or drains.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Shared decode of the current character as a hex digit and as a pair.
   always_comb begin
      digit = hex_decode(req_tdata);
      if (!high_valid_ff) begin
         pair = 8'd0;
      end else if (!digit.valid) begin
         pair = {4'd0, high_nibble_ff};
      end else begin
         pair = {high_nibble_ff, digit.value};
      end
      addr_bytes     = addr_total_ff[3:1];
      addr_left_dec  = (addr_left_ff != 4'd0) ? addr_left_ff - 4'd1 : addr_left_ff;
      bytes_left_dec = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : bytes_left_ff;
   end

   // Next state of the line parser for the accepted character.
   always_comb begin
      phase_in       = phase_ff;
      addr_left_in   = addr_left_ff;
      addr_total_in  = addr_total_ff;
      bytes_left_in  = bytes_left_ff;
      high_nibble_in = high_nibble_ff;
      high_valid_in  = high_valid_ff;
      emit           = 1'b0;
      emit_last      = 1'b0;
      if (req_tdata == CHAR_NEWLINE) begin
         phase_in = PH_LINE_START;
      end else begin
         unique case (phase_ff)
            PH_LINE_START: begin
               phase_in = (req_tdata == CHAR_S) ? PH_TYPE : PH_SKIP;
            end
            PH_TYPE: begin
               if (req_tdata >= CHAR_ONE && req_tdata <= CHAR_THREE) begin
                  // S1, S2 and S3 carry 4, 6 and 8 address digits.
                  addr_total_in = {1'b0, req_tdata[1:0], 1'b0} + 4'd2;
                  phase_in      = PH_COUNT_HI;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_COUNT_HI: begin
               high_valid_in  = digit.valid;
               high_nibble_in = digit.valid ? digit.value : 4'd0;
               phase_in       = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
               // A count that does not cover the address gives no payload.
               if (pair > {5'd0, addr_bytes}) begin
                  bytes_left_in = pair - {5'd0, addr_bytes} - 8'd1;
               end else begin
                  bytes_left_in = 8'd0;
               end
               addr_left_in = addr_total_ff;
               phase_in     = PH_ADDR;
            end
            PH_ADDR: begin
               addr_left_in = addr_left_dec;
               if (addr_left_dec == 4'd0) begin
                  phase_in = (bytes_left_ff != 8'd0) ? PH_DATA_HI : PH_SKIP;
               end
            end
            PH_DATA_HI: begin
               high_valid_in  = digit.valid;
               high_nibble_in = digit.valid ? digit.value : 4'd0;
               phase_in       = PH_DATA_LO;
            end
            PH_DATA_LO: begin
               emit          = 1'b1;
               bytes_left_in = bytes_left_dec;
               if (bytes_left_dec == 8'd0) begin
                  emit_last = 1'b1;
                  phase_in  = PH_SKIP;
               end else begin
                  phase_in = PH_DATA_HI;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase
      end
   end

   // Output register loads on a produced byte and empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pair;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE_START;
         addr_left_ff   <= 4'd0;
         addr_total_ff  <= 4'd0;
         bytes_left_ff  <= 8'd0;
         high_nibble_ff <= 4'd0;
         high_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            addr_left_ff   <= addr_left_in;
            addr_total_ff  <= addr_total_in;
            bytes_left_ff  <= bytes_left_in;
            high_nibble_ff <= high_nibble_in;
            high_valid_ff  <= high_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // A newline always puts the parser back at the start of a line.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata == CHAR_NEWLINE) |=> (phase_ff == PH_LINE_START))
      else $error("newline did not return the parser to line start");

   // A byte in flight is never overwritten by a new character.
   assert property (@(posedge clock) disable iff (reset)
      !(accept && rsp_valid_ff && !rsp_tready))
      else $error("input taken while an output beat was stalled");

   // The last byte of a record coincides with the parser leaving the payload.
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (rsp_valid_ff && (rsp_last_ff == (phase_ff == PH_SKIP))))
      else $error("record end flag disagrees with the parser phase");

   // While decoding payload pairs, at least one byte is still owed.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA_HI || phase_ff == PH_DATA_LO) |-> (bytes_left_ff != 8'd0))
      else $error("payload phase with no bytes left");
`endif

endmodule
